[hw/rtl/ssfr_pkg.sv]
// ----------------------------------------------------------------------------
// ssfr_pkg
// Shared constants and codes for the stuffed frame receiver.
// ----------------------------------------------------------------------------
package ssfr_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 35;

    localparam logic [7:0] SYNC_BYTE = 8'h1B;
    localparam logic [7:0] AMP_ADDR  = 8'hFD;
    localparam logic [7:0] CHG_ADDR  = 8'hFE;

    typedef logic [2:0] event_t;
    localparam event_t EV_FRAME_OK   = 3'd0;
    localparam event_t EV_SYNC_EXP   = 3'd1;
    localparam event_t EV_UNEXP_SYNC = 3'd2;
    localparam event_t EV_TOO_LONG   = 3'd3;
    localparam event_t EV_CSUM_ERR   = 3'd4;

    typedef logic [1:0] class_t;
    localparam class_t CLS_COMMAND = 2'd0;
    localparam class_t CLS_AMP     = 2'd1;
    localparam class_t CLS_CHARGER = 2'd2;

endpackage

[hw/rtl/sync_stuffed_frame_receiver.sv]
// ----------------------------------------------------------------------------
// sync_stuffed_frame_receiver
// Rebuilds sync-led, byte-stuffed frames from received bytes and checks the
// additive checksum; reports one frame or error event per finished frame.
// ----------------------------------------------------------------------------
// Result path: an accepted byte is held in the input register, and its result
// then in the result register; a byte that ends no frame gives no result.
// Throughput: one byte per cycle, limited only by result back-pressure.
// Reset: synchronous, active low; clears the frame state and both valid flags.
module sync_stuffed_frame_receiver #(
    parameter int MAX_FRAME_BYTES = ssfr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_rx_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output ssfr_pkg::event_t  m_event_res,
    output ssfr_pkg::class_t  m_frame_class,
    output logic [7:0]        m_address,
    output logic [4:0]        m_payload_length,
    output logic [7:0]        m_command,
    output logic [7:0]        m_argument
);
    import ssfr_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [8:0] MAX_TOT = 9'(MAX_FRAME_BYTES);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;

    logic [POS_W-1:0] position_reg, position_next;
    logic             escape_reg, escape_next;
    logic [POS_W-1:0] total_reg, total_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       addr_reg, addr_next;
    logic [4:0]       len_reg, len_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [7:0]       arg_reg, arg_next;

    logic             out_valid_reg;
    event_t           ev_reg, ev_next;
    class_t           cls_reg, cls_next;
    logic [7:0]       o_addr_reg;
    logic [4:0]       o_len_reg;
    logic [7:0]       o_cmd_reg, o_arg_reg;
    logic             emit_next;

    logic             out_free;
    logic             proc_fire;
    logic [8:0]       tot;
    logic [POS_W-1:0] pos_inc;

    assign out_free  = !out_valid_reg || m_ready;
    assign proc_fire = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || proc_fire;

    assign tot     = {1'b0, in_byte_reg} + 9'd4;
    assign pos_inc = position_reg + POS_W'(1);

    always_comb begin
        position_next = position_reg;
        escape_next   = escape_reg;
        total_next    = total_reg;
        sum_next      = sum_reg;
        addr_next     = addr_reg;
        len_next      = len_reg;
        cmd_next      = cmd_reg;
        arg_next      = arg_reg;
        emit_next     = 1'b0;
        ev_next       = EV_FRAME_OK;
        cls_next      = CLS_COMMAND;
        priority if (position_reg == '0 && in_byte_reg != SYNC_BYTE) begin
            emit_next = 1'b1;
            ev_next   = EV_SYNC_EXP;
        end else if (position_reg == POS_W'(1) && in_byte_reg == SYNC_BYTE) begin
            position_next = '0;
            emit_next     = 1'b1;
            ev_next       = EV_UNEXP_SYNC;
        end else if (position_reg > POS_W'(1) && in_byte_reg == SYNC_BYTE
                     && !escape_reg) begin
            escape_next = 1'b1;
        end else if (position_reg == POS_W'(2) && tot > MAX_TOT) begin
            escape_next   = 1'b0;
            position_next = '0;
            emit_next     = 1'b1;
            ev_next       = EV_TOO_LONG;
        end else begin
            escape_next = 1'b0;
            if (position_reg == POS_W'(2)) begin
                total_next = tot[POS_W-1:0];
            end
            if (position_reg == '0) begin
                sum_next = '0;
                cmd_next = '0;
                arg_next = '0;
            end else begin
                sum_next = sum_reg + in_byte_reg;
            end
            if (position_reg == POS_W'(1)) begin
                addr_next = in_byte_reg;
            end
            if (position_reg == POS_W'(2)) begin
                len_next = in_byte_reg[4:0];
            end
            if (position_reg == POS_W'(3)) begin
                cmd_next = in_byte_reg;
            end
            if (position_reg == POS_W'(4)) begin
                arg_next = in_byte_reg;
            end
            if (pos_inc < POS_W'(3) || pos_inc < total_next) begin
                position_next = pos_inc;
            end else begin
                position_next = '0;
                emit_next     = 1'b1;
                if (sum_next != 8'd0) begin
                    ev_next = EV_CSUM_ERR;
                end else begin
                    ev_next = EV_FRAME_OK;
                    priority if (addr_next == AMP_ADDR) begin
                        cls_next = CLS_AMP;
                    end else if (addr_next == CHG_ADDR) begin
                        cls_next = CLS_CHARGER;
                    end else begin
                        cls_next = CLS_COMMAND;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            position_reg  <= '0;
            escape_reg    <= 1'b0;
            total_reg     <= '0;
            sum_reg       <= '0;
            addr_reg      <= '0;
            len_reg       <= '0;
            cmd_reg       <= '0;
            arg_reg       <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= proc_fire && emit_next;
            end
            if (proc_fire) begin
                position_reg <= position_next;
                escape_reg   <= escape_next;
                total_reg    <= total_next;
                sum_reg      <= sum_next;
                addr_reg     <= addr_next;
                len_reg      <= len_next;
                cmd_reg      <= cmd_next;
                arg_reg      <= arg_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
        if (proc_fire && emit_next) begin
            ev_reg <= ev_next;
            if (ev_next == EV_FRAME_OK) begin
                cls_reg    <= cls_next;
                o_addr_reg <= addr_next;
                o_len_reg  <= len_next;
                o_cmd_reg  <= cmd_next;
                o_arg_reg  <= arg_next;
            end else begin
                cls_reg    <= CLS_COMMAND;
                o_addr_reg <= '0;
                o_len_reg  <= '0;
                o_cmd_reg  <= '0;
                o_arg_reg  <= '0;
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_event_res      = ev_reg;
    assign m_frame_class    = cls_reg;
    assign m_address        = o_addr_reg;
    assign m_payload_length = o_len_reg;
    assign m_command        = o_cmd_reg;
    assign m_argument       = o_arg_reg;

endmodule

[hw/rtl/ssfr_checker.sv]
// ----------------------------------------------------------------------------
// ssfr_checker
// Port-level checks on the stuffed frame receiver's result channel.
// ----------------------------------------------------------------------------
module ssfr_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input ssfr_pkg::event_t  m_event_res,
    input ssfr_pkg::class_t  m_frame_class,
    input logic [7:0]        m_address,
    input logic [4:0]        m_payload_length,
    input logic [7:0]        m_command,
    input logic [7:0]        m_argument
);
    import ssfr_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_res)
            && $stable(m_address) && $stable(m_command))
        else $error("result item changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res != EV_FRAME_OK |->
            m_frame_class == CLS_COMMAND && m_address == 8'd0
            && m_payload_length == 5'd0 && m_command == 8'd0 && m_argument == 8'd0)
        else $error("error event carries frame fields");

    a_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EV_FRAME_OK |->
            (m_frame_class == CLS_AMP && m_address == AMP_ADDR)
            || (m_frame_class == CLS_CHARGER && m_address == CHG_ADDR)
            || (m_frame_class == CLS_COMMAND && m_address != AMP_ADDR
                && m_address != CHG_ADDR))
        else $error("frame class does not match address");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_event_res == EV_FRAME_OK || m_event_res == EV_SYNC_EXP
            || m_event_res == EV_UNEXP_SYNC || m_event_res == EV_TOO_LONG
            || m_event_res == EV_CSUM_ERR)
        else $error("undefined event code");

endmodule

bind sync_stuffed_frame_receiver ssfr_checker u_ssfr_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_event_res      (m_event_res),
    .m_frame_class    (m_frame_class),
    .m_address        (m_address),
    .m_payload_length (m_payload_length),
    .m_command        (m_command),
    .m_argument       (m_argument)
);
